FILE: design/spnc_pkg.sv
// Package for the counter-mode byte cipher: register map, reset values,
// configuration struct and the S-box and permutation functions.
// No dependencies.
package spnc_pkg;

  localparam int ROUNDS        = 3;
  localparam int KEY_REUSE_IDX = 2;
  localparam int KEY_FINAL_IDX = 3;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;

  localparam logic [1:0] REG_CIPHER_KEY      = 2'd0;
  localparam logic [1:0] REG_SBOX_TABLE      = 2'd1;
  localparam logic [1:0] REG_PERM_TABLE      = 2'd2;
  localparam logic [1:0] REG_INITIAL_COUNTER = 2'd3;

  localparam logic [31:0] CIPHER_KEY_RST      = 32'h0000_0000;
  localparam logic [63:0] SBOX_TABLE_RST      = 64'hFEDC_BA98_7654_3210;
  localparam logic [23:0] PERM_TABLE_RST      = 24'h05_3977;
  localparam logic [7:0]  INITIAL_COUNTER_RST = 8'h00;

  typedef struct packed {
    logic [31:0] cipher_key;
    logic [63:0] sbox_table;
    logic [23:0] perm_table;
  } spnc_cfg_t;

  function automatic logic [7:0] sub_byte(input logic [63:0] sbox, input logic [7:0] b);
    logic [7:0] r;
    r[7:4] = sbox[4*b[7:4] +: 4];
    r[3:0] = sbox[4*b[3:0] +: 4];
    return r;
  endfunction

  function automatic logic [7:0] permute_byte(input logic [23:0] perm, input logic [7:0] b);
    logic [7:0] r;
    logic [2:0] src;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      src = perm[3*i +: 3];
      r[7-i] = b[src];
    end
    return r;
  endfunction

endpackage

FILE: design/spnc_keystream.sv
// Keystream generator: all cipher rounds on one counter value, unrolled.
// Depends on spnc_pkg.
module spnc_keystream import spnc_pkg::*; (
  input  spnc_cfg_t  cfg,
  input  logic [7:0] counter,
  output logic [7:0] keystream
);

  logic [7:0] state [0:ROUNDS];

  assign state[0] = counter;

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    localparam int KIdx = (r < KEY_REUSE_IDX) ? r : KEY_REUSE_IDX;
    logic [7:0] mixed;
    assign mixed        = state[r] ^ cfg.cipher_key[8*KIdx +: 8];
    assign state[r+1]   = permute_byte(cfg.perm_table, sub_byte(cfg.sbox_table, mixed));
  end

  assign keystream = state[ROUNDS] ^ cfg.cipher_key[8*KEY_FINAL_IDX +: 8];

endmodule

FILE: design/spn_byte_cipher_ctr.sv
// Top level of the counter-mode byte cipher: configuration registers,
// block counter, input stage and result register.
// Depends on spnc_pkg and spnc_keystream.
//
// Usage:
//   Input channel in_valid/in_stall carries a plaintext byte and a restart
//   flag; a transfer with restart set reloads the counter from
//   initial_counter before that byte. Every input transfer gives exactly one
//   result on out_valid/out_stall carrying the ciphertext byte.
//   The byte and its counter value are captured in the input stage, the
//   keystream is formed by the unrolled rounds and the result is held in the
//   output register. Throughput is one byte per cycle while out_stall is low,
//   set by the single pass through the round logic between the two stages.
//   When the receiver stalls, the result register holds; the input stage
//   still takes one byte, and in_stall rises only once both stages are full.
//   Registers are written over APB (byte address 8 * index) by the user only
//   with no transfer in flight, unenforced by the block. Reset empties both
//   stages, clears counter, restores defaults (identity S-box, permutation).
module spn_byte_cipher_ctr import spnc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_plain_byte,
  input  logic              in_restart,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_cipher_byte,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [31:0] cipher_key_r;
  logic [63:0] sbox_table_r;
  logic [23:0] perm_table_r;
  logic [7:0]  initial_counter_r;
  logic [1:0]  reg_idx;
  logic        cfg_wr;

  logic [7:0]  ctr_r;
  logic [7:0]  ctr_cur;
  logic        s1_valid_r;
  logic [7:0]  s1_plain_r;
  logic [7:0]  s1_ctr_r;
  logic        s2_valid_r;
  logic [7:0]  s2_cipher_r;
  logic        s2_free;
  logic        in_take;
  logic        s1_nxt_valid;
  logic [7:0]  keystream;
  spnc_cfg_t   cfg;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cipher_key_r      <= CIPHER_KEY_RST;
      sbox_table_r      <= SBOX_TABLE_RST;
      perm_table_r      <= PERM_TABLE_RST;
      initial_counter_r <= INITIAL_COUNTER_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_CIPHER_KEY:      cipher_key_r      <= pwdata[31:0];
        REG_SBOX_TABLE:      sbox_table_r      <= pwdata;
        REG_PERM_TABLE:      perm_table_r      <= pwdata[23:0];
        REG_INITIAL_COUNTER: initial_counter_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_CIPHER_KEY:      prdata[31:0] = cipher_key_r;
      REG_SBOX_TABLE:      prdata       = sbox_table_r;
      REG_PERM_TABLE:      prdata[23:0] = perm_table_r;
      REG_INITIAL_COUNTER: prdata[7:0]  = initial_counter_r;
      default:             prdata       = '0;
    endcase
  end

  // pipeline control
  assign s2_free      = !s2_valid_r || !out_stall;
  assign in_stall     = s1_valid_r && !s2_free;
  assign in_take      = in_valid && !in_stall;
  assign ctr_cur      = in_restart ? initial_counter_r : ctr_r;
  assign s1_nxt_valid = in_take || (s1_valid_r && !s2_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r      <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_nxt_valid;
      if (s2_free) begin
        s2_valid_r <= s1_valid_r;
      end
      if (in_take) begin
        ctr_r <= ctr_cur + 8'd1;
      end
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_plain_r <= in_plain_byte;
      s1_ctr_r   <= ctr_cur;
    end
  end

  assign cfg.cipher_key = cipher_key_r;
  assign cfg.sbox_table = sbox_table_r;
  assign cfg.perm_table = perm_table_r;

  spnc_keystream u_keystream (
    .cfg       (cfg),
    .counter   (s1_ctr_r),
    .keystream (keystream)
  );

  // result register
  always_ff @(posedge clk) begin
    if (s2_free && s1_valid_r) begin
      s2_cipher_r <= s1_plain_r ^ keystream;
    end
  end

  assign out_valid       = s2_valid_r;
  assign out_cipher_byte = s2_cipher_r;

endmodule

FILE: design/spnc_checker.sv
// Port-level checker for the counter-mode byte cipher, bound to the top level.
// Depends on spnc_pkg and spn_byte_cipher_ctr.
module spnc_checker import spnc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_cipher_byte
);

  // drop any result in flight on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cipher_byte))
    else $error("stalled result changed");

  // back-pressure only when the result register is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // an accepted transfer reaches the output register when nothing blocks it
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("accepted byte did not reach the output");

endmodule

bind spn_byte_cipher_ctr spnc_checker u_spnc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_cipher_byte (out_cipher_byte)
);

FILE: tb/sv/tb.sv
// Testbench for spn_byte_cipher_ctr: streams plaintext bytes with restarts,
// programs and reads back the registers over APB and checks every ciphertext
// byte against an in-bench keystream predictor. Depends on spnc_pkg and the DUT.
module tb import spnc_pkg::*;;

  localparam int IDLE_LIMIT      = 2000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int MAX_SHOWN       = 10;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 106;

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              in_valid        = 1'b0;
  logic              in_stall;
  logic [7:0]        in_plain_byte   = '0;
  logic              in_restart      = 1'b0;
  logic              out_valid;
  logic              out_stall       = 1'b0;
  logic [7:0]        out_cipher_byte;
  logic              psel            = 1'b0;
  logic              penable         = 1'b0;
  logic              pwrite          = 1'b0;
  logic [ADDR_W-1:0] paddr           = '0;
  logic [DATA_W-1:0] pwdata          = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic [31:0] key_m  = CIPHER_KEY_RST;
  logic [63:0] sbox_m = SBOX_TABLE_RST;
  logic [23:0] perm_m = PERM_TABLE_RST;
  logic [7:0]  ictr_m = INITIAL_COUNTER_RST;
  logic [7:0]  ctr_m  = '0;

  logic [7:0] cipher_q[$];
  logic [7:0] want_byte;
  int errors        = 0;
  int quiet_cycles  = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;

  spn_byte_cipher_ctr dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_plain_byte   (in_plain_byte),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cipher_byte (out_cipher_byte),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] keystream_byte(input logic [7:0] ctr);
    logic [7:0] m;
    logic [7:0] s;
    logic [7:0] p;
    int k;
    m = ctr;
    for (int r = 0; r < ROUNDS; r++) begin
      k = (r < KEY_REUSE_IDX) ? r : KEY_REUSE_IDX;
      m = m ^ key_m[8*k +: 8];
      s[7:4] = 4'(sbox_m >> (4 * m[7:4]));
      s[3:0] = 4'(sbox_m >> (4 * m[3:0]));
      for (int i = 0; i < 8; i++) begin
        p[7-i] = s[perm_m[3*i +: 3]];
      end
      m = p;
    end
    return m ^ key_m[8*KEY_FINAL_IDX +: 8];
  endfunction

  function automatic logic [DATA_W-1:0] shuffled(input int n, input int w);
    int slot[16];
    int j;
    int t;
    logic [DATA_W-1:0] r;
    for (int i = 0; i < n; i++) slot[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = slot[i];
      slot[i] = slot[j];
      slot[j] = t;
    end
    r = '0;
    for (int i = 0; i < n; i++) r = r | (DATA_W'(slot[i]) << (w * i));
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
    errors++;
    if (errors <= MAX_SHOWN) begin
      $display("mismatch on %s: expected %0h, actual %0h", what, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (cipher_q.size() == 0) begin
        report_mismatch("unexpected cipher_byte", '0, 64'(out_cipher_byte));
      end else begin
        want_byte = cipher_q.pop_front();
        if (out_cipher_byte !== want_byte) begin
          report_mismatch("cipher_byte", 64'(want_byte), 64'(out_cipher_byte));
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] plain, input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_plain_byte <= plain;
    in_restart    <= restart;
    do @(posedge clk); while (in_stall);
    if (restart) ctr_m = ictr_m;
    cipher_q.push_back(plain ^ keystream_byte(ctr_m));
    ctr_m = ctr_m + 8'd1;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_reg(input logic [1:0] idx);
    logic [DATA_W-1:0] rd;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] want;
    mask = '0;
    want = '0;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 3'b000};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_CIPHER_KEY: begin
        mask = 64'hFFFF_FFFF;
        want = DATA_W'(key_m);
      end
      REG_SBOX_TABLE: begin
        mask = '1;
        want = sbox_m;
      end
      REG_PERM_TABLE: begin
        mask = 64'hFF_FFFF;
        want = DATA_W'(perm_m);
      end
      REG_INITIAL_COUNTER: begin
        mask = 64'hFF;
        want = DATA_W'(ictr_m);
      end
      default: ;
    endcase
    if ((rd & mask) !== want) report_mismatch("register read-back", want, rd & mask);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    case (idx)
      REG_CIPHER_KEY:      key_m  = value[31:0];
      REG_SBOX_TABLE:      sbox_m = value;
      REG_PERM_TABLE:      perm_m = value[23:0];
      REG_INITIAL_COUNTER: ictr_m = value[7:0];
      default: ;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    check_reg(idx);
  endtask

  task automatic test_reset_values();
    check_reg(REG_CIPHER_KEY);
    check_reg(REG_SBOX_TABLE);
    check_reg(REG_PERM_TABLE);
    check_reg(REG_INITIAL_COUNTER);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b1);
    send_byte(8'hC3, 1'b0);
    wait_idle();
  endtask

  task automatic test_counter_wrap();
    cfg_write(REG_CIPHER_KEY, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(REG_INITIAL_COUNTER, 64'hFF);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h3C, 1'b1);
    wait_idle();
  endtask

  task automatic test_degenerate_tables();
    cfg_write(REG_SBOX_TABLE, 64'h0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h7E, 1'b0);
    wait_idle();
    cfg_write(REG_SBOX_TABLE, '1);
    cfg_write(REG_PERM_TABLE, 64'h0);
    cfg_write(REG_CIPHER_KEY, 64'h0);
    send_byte(8'h12, 1'b0);
    send_byte(8'hED, 1'b0);
    wait_idle();
    cfg_write(REG_SBOX_TABLE, 64'h0123_4567_89AB_CDEF);
    cfg_write(REG_PERM_TABLE, 64'hFF_FFFF);
    cfg_write(REG_INITIAL_COUNTER, 64'h0);
    send_byte(8'h0F, 1'b1);
    send_byte(8'hF0, 1'b0);
    wait_idle();
  endtask

  task automatic test_round_keys();
    cfg_write(REG_CIPHER_KEY, 64'h9E37_79B9);
    cfg_write(REG_SBOX_TABLE, shuffled(16, 4));
    cfg_write(REG_PERM_TABLE, shuffled(8, 3));
    cfg_write(REG_INITIAL_COUNTER, 64'h80);
    send_byte(8'h00, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int send_mode[4] = '{0, 50, 0, 32};
    int recv_mode[4] = '{0, 0, 50, 32};
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      cfg_write(REG_CIPHER_KEY, {$urandom, $urandom});
      cfg_write(REG_SBOX_TABLE, $urandom_range(1) ? shuffled(16, 4) : {$urandom, $urandom});
      cfg_write(REG_PERM_TABLE, $urandom_range(1) ? shuffled(8, 3) : {$urandom, $urandom});
      cfg_write(REG_INITIAL_COUNTER, {$urandom, $urandom});
      send_idle_pct = send_mode[p % 4];
      stall_pct     = recv_mode[p % 4];
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_byte(8'($urandom), (i == 0) || ($urandom_range(31) == 0));
      end
      wait_idle();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_counter_wrap();
    test_degenerate_tables();
    test_round_keys();
    test_random_traffic();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    do @(posedge clk); while (quiet_cycles < IDLE_LIMIT);
    $display("FAIL");
    $finish;
  end

endmodule

FILE: spn_byte_cipher_ctr.f
design/spnc_pkg.sv
design/spnc_keystream.sv
design/spn_byte_cipher_ctr.sv
design/spnc_checker.sv
tb/sv/tb.sv
